>>> hw/rtl/tksd_pkg.sv
// Shared types, constants and lookup functions for the terminal key sequence decoder.
// Used by terminal_key_sequence_decoder; no other dependencies.
package tksd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KEY_W  = 12;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned NUM_W  = 7;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_TILDE   = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_HOME    = 8'h48;
  localparam logic [BYTE_W-1:0] CH_END     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_ARROW_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_ARROW_D = 8'h44;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] MOD_CTRL   = 8'h35;
  localparam logic [BYTE_W-1:0] MOD_SHIFT  = 8'h32;

  localparam logic [KEY_W-1:0] KEY_BARE_ESC = 12'd27;
  localparam logic [KEY_W-1:0] KEY_ARROW    = 12'd1001;
  localparam logic [KEY_W-1:0] KEY_HOME     = 12'd1010;
  localparam logic [KEY_W-1:0] KEY_END      = 12'd1011;
  localparam logic [KEY_W-1:0] KEY_PGUP     = 12'd1012;
  localparam logic [KEY_W-1:0] KEY_PGDN     = 12'd1013;
  localparam logic [KEY_W-1:0] KEY_DELETE   = 12'd1014;
  localparam logic [KEY_W-1:0] KEY_F5       = 12'd1020;
  localparam logic [KEY_W-1:0] KEY_ALT      = 12'd2000;
  localparam logic [KEY_W-1:0] OFS_CTRL     = 12'd100;
  localparam logic [KEY_W-1:0] OFS_SHIFT    = 12'd200;
  localparam logic [KEY_W-1:0] KEY_MAX      = 12'd2255;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_DIGIT = 3'd3,
    PH_MOD   = 3'd4,
    PH_DIR   = 3'd5,
    PH_TILDE = 3'd6
  } phase_t;

  // Key for ESC [ n ~ with a single digit n.
  function automatic logic [KEY_W-1:0] tilde_key(input logic [DIG_W-1:0] d);
    logic [KEY_W-1:0] k;
    unique case (d)
      4'd1:    k = KEY_HOME;
      4'd4:    k = KEY_END;
      4'd5:    k = KEY_PGUP;
      4'd6:    k = KEY_PGDN;
      4'd3:    k = KEY_DELETE;
      default: k = KEY_BARE_ESC;
    endcase
    return k;
  endfunction

  // Function keys F5 to F12 from the two-digit code.
  function automatic logic [KEY_W-1:0] fkey(input logic [NUM_W-1:0] n);
    logic [KEY_W-1:0] k;
    unique case (n)
      7'd15:   k = KEY_F5;
      7'd17:   k = KEY_F5 + 12'd1;
      7'd18:   k = KEY_F5 + 12'd2;
      7'd19:   k = KEY_F5 + 12'd3;
      7'd20:   k = KEY_F5 + 12'd4;
      7'd21:   k = KEY_F5 + 12'd5;
      7'd23:   k = KEY_F5 + 12'd6;
      7'd24:   k = KEY_F5 + 12'd7;
      default: k = KEY_BARE_ESC;
    endcase
    return k;
  endfunction

endpackage

>>> hw/rtl/terminal_key_sequence_decoder.sv
// Terminal key sequence decoder: turns terminal input bytes into key codes.
// Depends on tksd_pkg for the phase type, key constants and lookup functions.
//
// Usage:
//   The input stream carries one terminal byte per word in in_tdata, with
//   in_tlast set when no further byte follows at once (end of a read burst).
//   The output stream carries one key code per word in out_tdata[11:0].
//   Plain bytes give their own value; escape sequences give one key code
//   when they end, and bytes inside a sequence give no word.
//   A burst end in the middle of a sequence, or a byte that fits no known
//   pattern, ends the sequence with the bare escape code 27.
// Timing:
//   A byte is captured in an input register and decoded by the parser from
//   there; when the parser advances, its key code is loaded into the output
//   register, so the last byte of a sequence passes the input register and
//   then the output register before out_tvalid rises.
//   One byte is accepted every cycle while the output does not stall; the
//   parser's state update for each byte sets that rate.
// Reset and stalls:
//   rst_n empties both pipeline registers and returns the parser to idle.
//   While the receiver holds out_tready low with a word pending, the parser
//   holds; the input register takes one more byte if it is empty, then
//   in_tready drops.
module terminal_key_sequence_decoder
  import tksd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,   // [7:0] in_byte
  input  logic                   in_tlast,   // burst_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [11:0] key_code, [15:12] zero
);

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  phase_t            phase_r, phase_nxt;
  logic [DIG_W-1:0]  first_digit_r, first_digit_nxt;
  logic [NUM_W-1:0]  csi_number_r, csi_number_nxt;
  logic [BYTE_W-1:0] modifier_r, modifier_nxt;

  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;

  logic              dec_adv;
  logic              emit;
  logic [KEY_W-1:0]  key;

  logic              is_digit;
  logic              is_arrow;
  logic [1:0]        arrow_ofs;
  logic [KEY_W-1:0]  arrow_key;
  logic [DIG_W-1:0]  digit_val;
  logic [NUM_W-1:0]  fd_ext;

  // The parser advances whenever a byte waits and the output slot is free.
  assign dec_adv   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || dec_adv;

  assign is_digit  = (s1_byte_r >= CH_ZERO) && (s1_byte_r <= CH_NINE);
  assign is_arrow  = (s1_byte_r >= CH_ARROW_A) && (s1_byte_r <= CH_ARROW_D);
  // A to D sit at 0x41 to 0x44, so the low two bits wrap into 0 to 3.
  assign arrow_ofs = s1_byte_r[1:0] - CH_ARROW_A[1:0];
  assign arrow_key = KEY_ARROW + KEY_W'(arrow_ofs);
  assign digit_val = s1_byte_r[DIG_W-1:0];
  assign fd_ext    = NUM_W'(first_digit_r);

  always_comb begin
    phase_nxt       = PH_IDLE;
    first_digit_nxt = first_digit_r;
    csi_number_nxt  = csi_number_r;
    modifier_nxt    = modifier_r;
    emit            = 1'b1;
    key             = KEY_BARE_ESC;
    unique case (phase_r)
      PH_ESC: begin
        if (s1_byte_r == CH_LBRACK) begin
          if (!s1_last_r) begin
            phase_nxt = PH_CSI;
            emit      = 1'b0;
          end
        end else begin
          key = KEY_ALT + KEY_W'(s1_byte_r);
        end
      end
      PH_CSI: begin
        priority if (is_arrow) begin
          key = arrow_key;
        end else if (s1_byte_r == CH_HOME) begin
          key = KEY_HOME;
        end else if (s1_byte_r == CH_END) begin
          key = KEY_END;
        end else if (is_digit && !s1_last_r) begin
          first_digit_nxt = digit_val;
          phase_nxt       = PH_DIGIT;
          emit            = 1'b0;
        end else begin
          key = KEY_BARE_ESC;
        end
      end
      PH_DIGIT: begin
        priority if (s1_byte_r == CH_TILDE) begin
          key = tilde_key(first_digit_r);
        end else if (first_digit_r == DIG_W'(1) && s1_byte_r == CH_SEMI) begin
          if (!s1_last_r) begin
            phase_nxt = PH_MOD;
            emit      = 1'b0;
          end
        end else if (is_digit) begin
          if (!s1_last_r) begin
            // Two-digit code: first digit times ten plus the second.
            csi_number_nxt = (fd_ext << 3) + (fd_ext << 1) + NUM_W'(digit_val);
            phase_nxt      = PH_TILDE;
            emit           = 1'b0;
          end
        end else begin
          key = KEY_BARE_ESC;
        end
      end
      PH_MOD: begin
        modifier_nxt = s1_byte_r;
        if (!s1_last_r) begin
          phase_nxt = PH_DIR;
          emit      = 1'b0;
        end
      end
      PH_DIR: begin
        if (is_arrow && modifier_r == MOD_CTRL) begin
          key = arrow_key + OFS_CTRL;
        end else if (is_arrow && modifier_r == MOD_SHIFT) begin
          key = arrow_key + OFS_SHIFT;
        end
      end
      PH_TILDE: begin
        if (s1_byte_r == CH_TILDE) begin
          key = fkey(csi_number_r);
        end
      end
      default: begin
        if (s1_byte_r != CH_ESC) begin
          key = KEY_W'(s1_byte_r);
        end else if (!s1_last_r) begin
          phase_nxt = PH_ESC;
          emit      = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      first_digit_r <= '0;
      csi_number_r  <= '0;
      modifier_r    <= '0;
    end else if (dec_adv) begin
      phase_r       <= phase_nxt;
      first_digit_r <= first_digit_nxt;
      csi_number_r  <= csi_number_nxt;
      modifier_r    <= modifier_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= dec_adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_adv && emit) begin
      out_key_r <= key;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_key_r);

`ifndef SYNTH
  // Reset leaves the parser idle and both pipeline registers empty.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (phase_r == PH_IDLE && !s1_valid_r && !out_valid_r))
    else $error("decoder not idle after reset");

  // Every emitted key ends the sequence in progress.
  a_emit_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_adv && emit) |=> (phase_r == PH_IDLE))
    else $error("parser left a sequence open after emitting a key");

  // A burst end always closes any open sequence.
  a_burst_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (dec_adv && s1_last_r) |=> (phase_r == PH_IDLE && out_valid_r))
    else $error("burst end did not close the sequence with a key");

  // Key codes stay inside the defined range.
  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_key_r <= KEY_MAX))
    else $error("key code out of range");

  // With the output slot empty the input side never stalls.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with no pending output");
`endif

endmodule

>>> tb/sv/tksd_key_scoreboard_pkg.sv
// Scoreboard for the terminal key sequence decoder testbench: it tracks the escape
// sequence parser, predicts key codes and compares them against the output stream.
// Depends on tksd_pkg for the phase type, byte constants and key constants.
package tksd_tb_pkg;
  import tksd_pkg::*;

  class key_scoreboard;
    localparam int unsigned MAX_SHOWN = 100;

    phase_t             phase;
    logic [DIG_W-1:0]   lead_digit;
    logic [NUM_W-1:0]   seq_number;
    logic [BYTE_W-1:0]  modifier_seen;
    logic [KEY_W-1:0]   awaited_keys[$];
    int unsigned        bytes_seen;
    int unsigned        keys_checked;
    int unsigned        special_keys;
    int unsigned        alt_keys;
    int unsigned        bare_escapes;
    int unsigned        errors;

    function new();
      phase         = PH_IDLE;
      lead_digit    = '0;
      seq_number    = '0;
      modifier_seen = '0;
      bytes_seen    = 0;
      keys_checked  = 0;
      special_keys  = 0;
      alt_keys      = 0;
      bare_escapes  = 0;
      errors        = 0;
    endfunction

    function automatic bit is_digit(logic [BYTE_W-1:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_arrow(logic [BYTE_W-1:0] b);
      return b >= CH_ARROW_A && b <= CH_ARROW_D;
    endfunction

    function int unsigned pending();
      return awaited_keys.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_SHOWN) begin
        $display("ERROR: %s", msg);
      end else if (errors == MAX_SHOWN) begin
        $display("ERROR: further mismatches are counted but not shown");
      end
      errors++;
    endtask

    // Advances the parser by one accepted word and queues the key it completes.
    function void note_byte(logic [BYTE_W-1:0] b, logic burst_end);
      logic [KEY_W-1:0] key;
      bit               done;
      phase_t           prev;
      key  = KEY_BARE_ESC;
      done = 1'b1;
      prev = phase;
      phase = PH_IDLE;
      bytes_seen++;
      case (prev)
        PH_ESC: begin
          if (b == CH_LBRACK) begin
            if (!burst_end) begin
              phase = PH_CSI;
              done  = 1'b0;
            end
          end else begin
            key = KEY_ALT + KEY_W'(b);
          end
        end
        PH_CSI: begin
          if (is_arrow(b)) begin
            key = KEY_ARROW + KEY_W'(b - CH_ARROW_A);
          end else if (b == CH_HOME) begin
            key = KEY_HOME;
          end else if (b == CH_END) begin
            key = KEY_END;
          end else if (is_digit(b) && !burst_end) begin
            lead_digit = DIG_W'(b - CH_ZERO);
            phase      = PH_DIGIT;
            done       = 1'b0;
          end
        end
        PH_DIGIT: begin
          if (b == CH_TILDE) begin
            case (lead_digit)
              4'd1:    key = KEY_HOME;
              4'd4:    key = KEY_END;
              4'd5:    key = KEY_PGUP;
              4'd6:    key = KEY_PGDN;
              4'd3:    key = KEY_DELETE;
              default: key = KEY_BARE_ESC;
            endcase
          end else if (lead_digit == 4'd1 && b == CH_SEMI) begin
            if (!burst_end) begin
              phase = PH_MOD;
              done  = 1'b0;
            end
          end else if (is_digit(b)) begin
            if (!burst_end) begin
              seq_number = NUM_W'(lead_digit * 10 + (b - CH_ZERO));
              phase      = PH_TILDE;
              done       = 1'b0;
            end
          end
        end
        PH_MOD: begin
          // The modifier byte is kept even when a burst end cuts the sequence.
          modifier_seen = b;
          if (!burst_end) begin
            phase = PH_DIR;
            done  = 1'b0;
          end
        end
        PH_DIR: begin
          if (is_arrow(b) && modifier_seen == MOD_CTRL) begin
            key = KEY_ARROW + KEY_W'(b - CH_ARROW_A) + OFS_CTRL;
          end else if (is_arrow(b) && modifier_seen == MOD_SHIFT) begin
            key = KEY_ARROW + KEY_W'(b - CH_ARROW_A) + OFS_SHIFT;
          end
        end
        PH_TILDE: begin
          if (b == CH_TILDE) begin
            case (seq_number)
              7'd15:   key = KEY_F5;
              7'd17:   key = KEY_F5 + 12'd1;
              7'd18:   key = KEY_F5 + 12'd2;
              7'd19:   key = KEY_F5 + 12'd3;
              7'd20:   key = KEY_F5 + 12'd4;
              7'd21:   key = KEY_F5 + 12'd5;
              7'd23:   key = KEY_F5 + 12'd6;
              7'd24:   key = KEY_F5 + 12'd7;
              default: key = KEY_BARE_ESC;
            endcase
          end
        end
        default: begin
          if (b != CH_ESC) begin
            key = KEY_W'(b);
          end else if (!burst_end) begin
            phase = PH_ESC;
            done  = 1'b0;
          end
        end
      endcase
      if (done) begin
        awaited_keys = {awaited_keys, key};
        if (prev != PH_IDLE && key == KEY_BARE_ESC) begin
          bare_escapes++;
        end else if (key >= KEY_ALT) begin
          alt_keys++;
        end else if (key >= KEY_ARROW) begin
          special_keys++;
        end
      end
    endfunction

    task check_key(logic [OUT_TDATA_W-1:0] word);
      logic [KEY_W-1:0] got;
      logic [KEY_W-1:0] want;
      got = word[KEY_W-1:0];
      if (awaited_keys.size() == 0) begin
        report_mismatch($sformatf("key code %0d arrived with none expected", got));
      end else begin
        want = awaited_keys.pop_front();
        keys_checked++;
        if (got !== want) begin
          report_mismatch($sformatf("key code %0d, expected %0d (result %0d)",
                                    got, want, keys_checked));
        end
        if (word[OUT_TDATA_W-1:KEY_W] !== '0) begin
          report_mismatch($sformatf("padding bits of word %0d are 0x%0h, expected zero",
                                    keys_checked, word[OUT_TDATA_W-1:KEY_W]));
        end
      end
    endtask
  endclass

endpackage

>>> tb/sv/terminal_key_sequence_decoder_test.sv
// Top-level testbench for terminal_key_sequence_decoder: directed and random byte
// streams with random stalls on both sides, checked word by word by the scoreboard.
// Depends on tksd_pkg and tksd_tb_pkg.
module terminal_key_sequence_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tksd_pkg::*;
  import tksd_tb_pkg::*;

  localparam int unsigned TOTAL_ITEMS  = 1450;
  localparam int unsigned STEADY_ITEMS = 200;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              burst_end;
  } term_byte_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;   // [7:0] in_byte
  logic                   in_tlast   = 1'b0; // burst_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [11:0] key_code, [15:12] zero

  key_scoreboard sb = new();
  term_byte_t    byte_plan[$];
  int unsigned   items_sent = 0;
  int unsigned   cycle_count = 0;
  bit            steady = 1'b0;

  terminal_key_sequence_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_byte(in_tdata, in_tlast);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_key(out_tdata);
    end
  end

  task automatic plan_byte(logic [BYTE_W-1:0] b, logic burst_end);
    term_byte_t w;
    w.value     = b;
    w.burst_end = burst_end;
    byte_plan = {byte_plan, w};
  endtask

  // Burst ends fall mostly on the closing byte, now and then in mid-sequence.
  task automatic plan_seq_byte(logic [BYTE_W-1:0] b, bit closing);
    plan_byte(b, closing ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 24) == 0));
  endtask

  task automatic send_plan();
    term_byte_t w;
    while (byte_plan.size() != 0) begin
      w = byte_plan.pop_front();
      if (!steady && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= w.value;
      in_tlast  <= w.burst_end;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      items_sent++;
    end
  endtask

  task automatic plan_random_sequence();
    int unsigned       pick;
    int unsigned       n;
    logic [BYTE_W-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      plan_seq_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    end else begin
      plan_seq_byte(CH_ESC, 1'b0);
      if (pick < 35) begin
        plan_seq_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
      end else begin
        plan_seq_byte(CH_LBRACK, 1'b0);
        if (pick < 45) begin
          n = $urandom_range(0, 5);
          if (n < 4) b = CH_ARROW_A + BYTE_W'(n);
          else if (n == 4) b = CH_HOME;
          else b = CH_END;
          plan_seq_byte(b, 1'b1);
        end else if (pick < 57) begin
          plan_seq_byte(CH_ZERO + BYTE_W'($urandom_range(0, 9)), 1'b0);
          b = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255)) : CH_TILDE;
          plan_seq_byte(b, 1'b1);
        end else if (pick < 71) begin
          plan_seq_byte(CH_ZERO + 8'd1, 1'b0);
          plan_seq_byte(CH_SEMI, 1'b0);
          n = $urandom_range(0, 4);
          if (n < 2) b = MOD_CTRL;
          else if (n < 4) b = MOD_SHIFT;
          else b = BYTE_W'($urandom_range(0, 255));
          plan_seq_byte(b, 1'b0);
          if ($urandom_range(0, 4) == 0) b = BYTE_W'($urandom_range(0, 255));
          else b = CH_ARROW_A + BYTE_W'($urandom_range(0, 3));
          plan_seq_byte(b, 1'b1);
        end else if (pick < 85) begin
          // Mostly the function-key codes 15 to 24, sometimes any two digits.
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99) : $urandom_range(15, 24);
          plan_seq_byte(CH_ZERO + BYTE_W'(n / 10), 1'b0);
          plan_seq_byte(CH_ZERO + BYTE_W'(n % 10), 1'b0);
          b = ($urandom_range(0, 7) == 0) ? BYTE_W'($urandom_range(0, 255)) : CH_TILDE;
          plan_seq_byte(b, 1'b1);
        end else begin
          n = $urandom_range(1, 3);
          repeat (n - 1) plan_seq_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
          plan_seq_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
      end
    end
  endtask

  // Receiver: random stalls, one long hold that backs up the input side.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && sb.bytes_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timed out after %0d cycles, %0d key codes outstanding",
             cycle_count, sb.pending());
    $display("terminal_key_sequence_decoder: mismatch");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, Alt keys, an arrow, a Ctrl arrow, a function key
    // with a burst end on its final byte, an unknown number and a cut sequence.
    plan_byte(8'h00, 1'b0);
    plan_byte(8'hFF, 1'b1);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(8'hFF, 1'b0);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_LBRACK, 1'b0);
    plan_byte(CH_ARROW_A, 1'b0);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_LBRACK, 1'b0);
    plan_byte(CH_ZERO + 8'd1, 1'b0);
    plan_byte(CH_SEMI, 1'b0);
    plan_byte(MOD_CTRL, 1'b0);
    plan_byte(CH_ARROW_D, 1'b0);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_LBRACK, 1'b0);
    plan_byte(CH_ZERO + 8'd2, 1'b0);
    plan_byte(CH_ZERO + 8'd4, 1'b0);
    plan_byte(CH_TILDE, 1'b1);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_LBRACK, 1'b0);
    plan_byte(CH_NINE, 1'b0);
    plan_byte(CH_TILDE, 1'b0);
    plan_byte(CH_ESC, 1'b0);
    plan_byte(CH_LBRACK, 1'b1);
    send_plan();

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - STEADY_ITEMS) steady = 1'b1;
      plan_random_sequence();
      send_plan();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch($sformatf("%0d key codes never arrived", sb.pending()));
    end

    $display("Decoded %0d input words into %0d key codes over %0d cycles.",
             sb.bytes_seen, sb.keys_checked, cycle_count);
    $display("Keys: %0d cursor/editing/function, %0d Alt, %0d bare escape; %0d errors.",
             sb.special_keys, sb.alt_keys, sb.bare_escapes, sb.errors);
    if (sb.errors == 0) begin
      $display("terminal_key_sequence_decoder: match");
    end else begin
      $display("terminal_key_sequence_decoder: mismatch");
    end
    $finish;
  end

endmodule
